### rtl/core/vpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_pkg
// Request and result types and code constants of the partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

	typedef struct packed {
		logic        cmd;
		logic [15:0] req_size;
		logic [15:0] target_pid;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] granted_pid;
		logic [15:0] grant_addr;
		logic [15:0] granted_size;
	} rsp_t;

	localparam logic       CMD_ALLOC = 1'b0;
	localparam logic       CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_ZERO     = 2'd2;
	localparam logic [1:0] ST_NOT_FND  = 2'd3;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;
	localparam logic [1:0] FIT_RSVD  = 2'd3;

	localparam logic [1:0] REG_FIT  = 2'd0;
	localparam logic [1:0] REG_MEM  = 2'd1;
	localparam logic [1:0] REG_FRAG = 2'd2;

	localparam logic [15:0] RESET_MEMORY   = 16'd1024;
	localparam logic [15:0] RESET_MIN_FRAG = 16'd10;

	// Operations broadcast to a row of table cells.
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_INIT   = 3'd1;
	localparam logic [2:0] OP_WRITE  = 3'd2;
	localparam logic [2:0] OP_DROP   = 3'd3;
	localparam logic [2:0] OP_INSERT = 3'd4;

	typedef struct packed {
		logic [2:0] op;
	} cell_ctl_t;

endpackage

### rtl/core/vpa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_cell
// One table entry: a word that can be loaded, taken from its right neighbor
// (drop) or from its left neighbor (insert).
// ----------------------------------------------------------------------------
module vpa_cell #(
	parameter int W   = 48,
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic              clk,
	input  vpa_pkg::cell_ctl_t ctl,
	input  logic [IW-1:0]     sel,
	input  logic [W-1:0]      wdata,
	input  logic [W-1:0]      init_data,
	input  logic [W-1:0]      left,
	input  logic [W-1:0]      right,
	output logic [W-1:0]      data
);
	logic [W-1:0] data_q;
	localparam logic [IW-1:0] ME = IW'(IDX);

	always_ff @(posedge clk) begin
		case (ctl.op)
			vpa_pkg::OP_INIT:   data_q <= init_data;
			vpa_pkg::OP_WRITE:  if (sel == ME) data_q <= wdata;
			vpa_pkg::OP_DROP:   if (ME >= sel) data_q <= right;
			vpa_pkg::OP_INSERT: begin
				if (ME == sel) data_q <= wdata;
				else if (ME > sel) data_q <= left;
			end
			default: ;
		endcase
	end

	assign data = data_q;
endmodule

### rtl/core/vpa_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_row
// A chain of table cells with a registered read at one walking index.
// ----------------------------------------------------------------------------
module vpa_row #(
	parameter int N  = 16,
	parameter int W  = 48,
	parameter int IW = 4
) (
	input  logic               clk,
	input  vpa_pkg::cell_ctl_t ctl,
	input  logic [IW-1:0]      sel,
	input  logic [W-1:0]       wdata,
	input  logic [W-1:0]       init_data,
	input  logic [IW-1:0]      raddr,
	output logic [W-1:0]       rdata
);
	logic [W-1:0] d [N];

	for (genvar i = 0; i < N; i++) begin : g_c
		vpa_cell #(.W(W), .IW(IW), .IDX(i)) u_c (
			.clk(clk), .ctl(ctl), .sel(sel), .wdata(wdata),
			.init_data(i == 0 ? init_data : '0),
			.left(i == 0 ? wdata : d[(i == 0) ? 0 : i-1]),
			.right(i == N-1 ? d[N-1] : d[(i == N-1) ? i : i+1]),
			.data(d[i])
		);
	end

	logic [W-1:0] rdata_q;
	always_ff @(posedge clk) rdata_q <= d[raddr];
	assign rdata = rdata_q;
endmodule

### rtl/core/variable_partition_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator
// Free-segment and allocated-block tables as rows of cells, one sequencer
// that walks them one entry a cycle.
// An allocate walks the free segments; with compaction it then relays the
// blocks; a free walks the blocks, then the segments. Zero size and a full
// block table answer without a walk. One request at a time; the next is taken
// in the cycle after the result is taken.
// Reset: registers to fit 0, memory 1024, min fragment 10; the segment row
// loads its single free segment in the first cycle after reset; no blocks;
// pid counter zero.
// ----------------------------------------------------------------------------
module variable_partition_allocator #(
	parameter int MAX_ENTRIES = 16,
	parameter int ADDR_BITS   = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  vpa_pkg::req_t           req,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output vpa_pkg::rsp_t           rsp,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_idx,
	input  logic [15:0]             cfg_wdata
);
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int FW = 2 * ADDR_BITS;
	localparam int UW = 16 + 2 * ADDR_BITS;
	localparam int TW = ADDR_BITS + CW;

	localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_DEC = 4'd2,
		S_MOVE = 4'd3, S_FSCAN = 4'd4, S_PSCAN = 4'd5, S_FDEC = 4'd6,
		S_UDROP = 4'd7, S_OUT = 4'd8, S_GRANT = 4'd9, S_WAIT = 4'd10;

	logic [3:0]           state_q;
	logic [1:0]           fit_q;
	logic [15:0]          mem_q, frag_q, pid_q;
	logic [CW-1:0]        fcnt_q, ucnt_q;
	logic [CW:0]          i_q;
	logic                 found_q, left_q, right_q;
	logic [IW-1:0]        pick_q, idx_q;
	logic [ADDR_BITS-1:0] psize_q, pstart_q, bs_q, bz_q, pnext_q;
	logic [TW-1:0]        total_q, addr_q;
	logic [15:0]          rsize_q, tpid_q;
	vpa_pkg::rsp_t        rsp_q;
	logic                 rv_q, rd_pipe_q, init_pend_q;

	vpa_pkg::cell_ctl_t   fctl, uctl;
	logic [IW-1:0]        fsel, usel, fra, ura;
	logic [FW-1:0]        fwd, frd;
	logic [UW-1:0]        uwd, urd;

	wire [15:0] init_size = (cfg_we && cfg_idx == vpa_pkg::REG_MEM) ? cfg_wdata : mem_q;

	vpa_row #(.N(MAX_ENTRIES), .W(FW), .IW(IW)) u_free (
		.clk(clk), .ctl(fctl), .sel(fsel), .wdata(fwd),
		.init_data({{ADDR_BITS{1'b0}}, ADDR_BITS'(init_size)}),
		.raddr(fra), .rdata(frd));
	vpa_row #(.N(MAX_ENTRIES), .W(UW), .IW(IW)) u_used (
		.clk(clk), .ctl(uctl), .sel(usel), .wdata(uwd),
		.init_data('0), .raddr(ura), .rdata(urd));

	wire [ADDR_BITS-1:0] fst = frd[FW-1:ADDR_BITS];
	wire [ADDR_BITS-1:0] fsz = frd[ADDR_BITS-1:0];
	wire [15:0]          upid = urd[UW-1:2*ADDR_BITS];
	wire [ADDR_BITS-1:0] ust = urd[2*ADDR_BITS-1:ADDR_BITS];
	wire [ADDR_BITS-1:0] usz = urd[ADDR_BITS-1:0];
	wire [ADDR_BITS-1:0] rq  = ADDR_BITS'(rsize_q);
	wire [ADDR_BITS-1:0] rem = psize_q - rq;
	wire                 split = (rem != '0) && (32'(rem) >= 32'(frag_q));
	wire [ADDR_BITS-1:0] gsize = split ? rq : psize_q;

	// Walk index: an upward read issued at i_q returns in the next cycle as entry
	// i_q-1; a downward read issued at i_q-1 returns as entry i_q.
	wire [CW:0]  rd_i = i_q - 1'b1;
	assign fra = i_q[IW-1:0];
	assign ura = rd_i[IW-1:0];

	assign req_ready = (state_q == S_IDLE) && !rv_q && !init_pend_q;
	assign rsp_valid = rv_q;
	assign rsp = rsp_q;

	always_comb begin
		fctl.op = vpa_pkg::OP_NONE; uctl.op = vpa_pkg::OP_NONE;
		fsel = pick_q; usel = ucnt_q[IW-1:0];
		fwd = {pstart_q + rq, rem};
		uwd = {pid_q, pstart_q, bz_q};
		if ((cfg_we && cfg_idx == vpa_pkg::REG_MEM) || init_pend_q) fctl.op = vpa_pkg::OP_INIT;
		else begin
			case (state_q)
				S_GRANT: begin
					fctl.op = split ? vpa_pkg::OP_WRITE : vpa_pkg::OP_DROP;
					uctl.op = vpa_pkg::OP_WRITE;
					uwd = {pid_q, pstart_q, gsize};
				end
				S_MOVE: begin
					if (rd_pipe_q) begin
						uctl.op = vpa_pkg::OP_WRITE; usel = i_q[IW-1:0];
						uwd = {upid, addr_q[ADDR_BITS-1:0], usz};
					end
					if (i_q == '0) begin
						fctl.op = vpa_pkg::OP_WRITE; fsel = '0;
						fwd = {{ADDR_BITS{1'b0}}, total_q[ADDR_BITS-1:0]};
					end
				end
				S_FDEC: begin
					fsel = pick_q;
					if (left_q && right_q) begin
						fctl.op = vpa_pkg::OP_WRITE; fsel = pick_q - 1'b1;
						fwd = {pstart_q, psize_q + bz_q + pnext_q};
					end else if (left_q) begin
						fctl.op = vpa_pkg::OP_WRITE; fsel = pick_q - 1'b1;
						fwd = {pstart_q, psize_q + bz_q};
					end else if (right_q) begin
						fctl.op = vpa_pkg::OP_WRITE;
						fwd = {bs_q, pnext_q + bz_q};
					end else if (fcnt_q < CW'(MAX_ENTRIES)) begin
						fctl.op = vpa_pkg::OP_INSERT; fwd = {bs_q, bz_q};
					end
				end
				S_UDROP: begin
					uctl.op = vpa_pkg::OP_DROP; usel = idx_q;
					if (left_q && right_q) begin
						fctl.op = vpa_pkg::OP_DROP; fsel = pick_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; fit_q <= vpa_pkg::FIT_FIRST;
			mem_q <= vpa_pkg::RESET_MEMORY; frag_q <= vpa_pkg::RESET_MIN_FRAG;
			pid_q <= '0; fcnt_q <= CW'(1); ucnt_q <= '0; rv_q <= 1'b0;
			i_q <= '0; rd_pipe_q <= 1'b0; init_pend_q <= 1'b1;
		end else begin
			init_pend_q <= 1'b0;
			if (rv_q && rsp_ready) rv_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					vpa_pkg::REG_FIT:  fit_q <= cfg_wdata[1:0];
					vpa_pkg::REG_MEM: begin
						mem_q <= cfg_wdata; ucnt_q <= '0;
						fcnt_q <= (cfg_wdata != '0) ? CW'(1) : '0;
					end
					vpa_pkg::REG_FRAG: frag_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (req_valid && req_ready) begin
					rsize_q <= req.req_size;
					tpid_q <= req.target_pid; rd_pipe_q <= 1'b0;
					found_q <= 1'b0; total_q <= '0;
					i_q <= (req.cmd == vpa_pkg::CMD_ALLOC) ? '0 : (CW+1)'(ucnt_q);
					if (req.cmd == vpa_pkg::CMD_ALLOC) begin
						pid_q <= pid_q + 16'd1;
						rsp_q <= {(req.req_size == '0) ? vpa_pkg::ST_ZERO : vpa_pkg::ST_NO_SPACE,
							pid_q + 16'd1, 32'd0};
						if (req.req_size == '0) state_q <= S_OUT;
						else if (ucnt_q >= CW'(MAX_ENTRIES)) state_q <= S_OUT;
						else state_q <= S_SCAN;
					end else begin
						rsp_q <= {vpa_pkg::ST_NOT_FND, req.target_pid, 32'd0};
						state_q <= S_FSCAN;
					end
				end
				S_SCAN: begin
					// fit scan and free total over the segment row
					if (rd_pipe_q) begin
						total_q <= total_q + TW'(fsz);
						if (fsz >= rq) begin
							if (!found_q || (fit_q == vpa_pkg::FIT_BEST && fsz < psize_q)
								|| (fit_q == vpa_pkg::FIT_WORST && fsz > psize_q)) begin
								if (!(found_q && fit_q != vpa_pkg::FIT_BEST &&
									fit_q != vpa_pkg::FIT_WORST)) begin
									pick_q <= rd_i[IW-1:0]; psize_q <= fsz;
									pstart_q <= fst;
								end
							end
							found_q <= 1'b1;
						end
					end
					if (i_q < (CW+1)'(fcnt_q)) begin
						i_q <= i_q + 1'b1; rd_pipe_q <= 1'b1;
					end else begin
						rd_pipe_q <= 1'b0; state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (found_q) state_q <= S_GRANT;
					else if (total_q < TW'(rsize_q)) state_q <= S_OUT;
					else begin
						addr_q <= total_q; i_q <= (CW+1)'(ucnt_q); state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					// relay blocks newest first after the merged free space
					if (rd_pipe_q) addr_q <= addr_q + TW'(usz);
					if (i_q != '0) begin
						i_q <= i_q - 1'b1; rd_pipe_q <= 1'b1;
					end else begin
						rd_pipe_q <= 1'b0; fcnt_q <= CW'(1); pick_q <= '0;
						pstart_q <= '0; psize_q <= total_q[ADDR_BITS-1:0];
						state_q <= S_GRANT;
					end
				end
				S_GRANT: begin
					bz_q <= gsize;
					if (!split) fcnt_q <= fcnt_q - 1'b1;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					ucnt_q <= ucnt_q + 1'b1;
					rsp_q <= {vpa_pkg::ST_DONE, pid_q, 16'(pstart_q), 16'(bz_q)};
					state_q <= S_OUT;
				end
				S_FSCAN: begin
					// newest matching pid, walking down
					if (rd_pipe_q && !found_q && upid == tpid_q) begin
						found_q <= 1'b1; idx_q <= i_q[IW-1:0];
						bs_q <= ust; bz_q <= usz;
					end
					if (i_q != '0 && !(rd_pipe_q && upid == tpid_q)) begin
						i_q <= i_q - 1'b1; rd_pipe_q <= 1'b1;
					end else begin
						rd_pipe_q <= 1'b0;
						if (found_q || (rd_pipe_q && upid == tpid_q)) begin
							i_q <= '0; left_q <= 1'b0; right_q <= 1'b0;
							state_q <= S_PSCAN;
						end else state_q <= S_OUT;
					end
				end
				S_PSCAN: begin
					// first segment at or above the block
					if (rd_pipe_q && fst >= bs_q) begin
						rd_pipe_q <= 1'b0; pick_q <= rd_i[IW-1:0];
						right_q <= (bs_q + bz_q == fst); pnext_q <= fsz;
						state_q <= S_FDEC;
					end else begin
						if (rd_pipe_q) begin
							pstart_q <= fst; psize_q <= fsz;
							left_q <= (fst + fsz == bs_q);
						end
						if (i_q < (CW+1)'(fcnt_q)) begin
							i_q <= i_q + 1'b1; rd_pipe_q <= 1'b1;
						end else begin
							rd_pipe_q <= 1'b0; pick_q <= fcnt_q[IW-1:0];
							state_q <= S_FDEC;
						end
					end
				end
				S_FDEC: begin
					if (left_q && right_q) begin
						fcnt_q <= fcnt_q - 1'b1; state_q <= S_UDROP;
					end else if (left_q || right_q) state_q <= S_UDROP;
					else if (fcnt_q < CW'(MAX_ENTRIES)) begin
						fcnt_q <= fcnt_q + 1'b1; state_q <= S_UDROP;
					end else begin
						rsp_q.status <= vpa_pkg::ST_NO_SPACE; state_q <= S_OUT;
					end
				end
				S_UDROP: begin
					ucnt_q <= ucnt_q - 1'b1;
					rsp_q <= {vpa_pkg::ST_DONE, tpid_q, 16'(bs_q), 16'(bz_q)};
					state_q <= S_OUT;
				end
				S_OUT: begin rv_q <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ucnt_q <= CW'(MAX_ENTRIES)) else $error("used count overflow");
	a_fcnt: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= CW'(MAX_ENTRIES)) else $error("free count overflow");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		rv_q |-> !req_ready) else $error("accept while result pending");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> rv_q) else $error("result not raised");
endmodule

### sim/tb_variable_partition_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_variable_partition_allocator
// Self-checking bench for the partition allocator. A directed table is
// followed by random phases under several register settings. A behavioral
// model of both tables predicts every result. Responses are compared field
// by field, in order; both handshakes idle in random bursts but in the last phase.
// ----------------------------------------------------------------------------
module tb_variable_partition_allocator;

	localparam int ENTRIES  = 16;
	localparam int IDLE_MAX = 5000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	vpa_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	vpa_pkg::rsp_t rsp;
	logic          cfg_we = 1'b0;
	logic [1:0]    cfg_idx = vpa_pkg::REG_FIT;
	logic [15:0]   cfg_wdata = '0;

	variable_partition_allocator #(.MAX_ENTRIES(ENTRIES), .ADDR_BITS(16)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// allocator state copy
	logic [1:0]  m_fit;
	int unsigned m_mem, m_frag;
	int unsigned seg_start [ENTRIES], seg_size [ENTRIES], seg_cnt;
	int unsigned blk_pid [ENTRIES], blk_start [ENTRIES], blk_size [ENTRIES], blk_cnt;
	int unsigned pid_next;

	vpa_pkg::rsp_t pending_rsp [$];
	int   errors = 0;
	bit   quiet = 1'b0;
	int   idle_cycles = 0;

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void clear_tables();
		blk_cnt = 0;
		seg_start[0] = 0;
		seg_size[0] = m_mem;
		seg_cnt = (m_mem != 0) ? 1 : 0;
	endfunction

	function automatic void drop_seg(int unsigned i);
		for (int unsigned k = i; k + 1 < seg_cnt; k++) begin
			seg_start[k] = seg_start[k + 1];
			seg_size[k] = seg_size[k + 1];
		end
		seg_cnt--;
	endfunction

	function automatic vpa_pkg::rsp_t predict_alloc(int unsigned sz);
		vpa_pkg::rsp_t o;
		int unsigned pick, total, addr, st, gs, rem;
		bit found;
		pid_next = (pid_next + 1) & 16'hFFFF;
		o = '{vpa_pkg::ST_NO_SPACE, pid_next[15:0], 16'd0, 16'd0};
		found = 1'b0;
		pick = 0;
		if (sz == 0) begin
			o.status = vpa_pkg::ST_ZERO;
			return o;
		end
		if (blk_cnt >= ENTRIES)
			return o;
		for (int unsigned i = 0; i < seg_cnt; i++) begin
			if (seg_size[i] < sz)
				continue;
			if (!found) begin
				pick = i;
				found = 1'b1;
				if (m_fit != vpa_pkg::FIT_BEST && m_fit != vpa_pkg::FIT_WORST)
					break;
			end else if (m_fit == vpa_pkg::FIT_BEST && seg_size[i] < seg_size[pick]) begin
				pick = i;
			end else if (m_fit == vpa_pkg::FIT_WORST && seg_size[i] > seg_size[pick]) begin
				pick = i;
			end
		end
		if (!found) begin
			total = 0;
			for (int unsigned i = 0; i < seg_cnt; i++)
				total += seg_size[i];
			if (total < sz)
				return o;
			addr = total;
			for (int k = int'(blk_cnt) - 1; k >= 0; k--) begin
				blk_start[k] = addr & 16'hFFFF;
				addr += blk_size[k];
			end
			seg_cnt = 1;
			seg_start[0] = 0;
			seg_size[0] = total;
			pick = 0;
		end
		st = seg_start[pick];
		rem = seg_size[pick] - sz;
		if (rem > 0 && rem >= m_frag) begin
			seg_start[pick] += sz;
			seg_size[pick] = rem;
			gs = sz;
		end else begin
			gs = seg_size[pick];
			drop_seg(pick);
		end
		blk_pid[blk_cnt] = pid_next;
		blk_start[blk_cnt] = st;
		blk_size[blk_cnt] = gs;
		blk_cnt++;
		o.status = vpa_pkg::ST_DONE;
		o.grant_addr = st[15:0];
		o.granted_size = gs[15:0];
		return o;
	endfunction

	function automatic vpa_pkg::rsp_t predict_free(int unsigned pid);
		vpa_pkg::rsp_t o;
		int unsigned idx, bs, bz, p;
		bit found, lft, rgt;
		o = '{vpa_pkg::ST_NOT_FND, pid[15:0], 16'd0, 16'd0};
		found = 1'b0;
		idx = 0;
		for (int j = int'(blk_cnt) - 1; j >= 0; j--) begin
			if (blk_pid[j] == pid) begin
				idx = j;
				found = 1'b1;
				break;
			end
		end
		if (!found)
			return o;
		bs = blk_start[idx];
		bz = blk_size[idx];
		p = 0;
		while (p < seg_cnt && seg_start[p] < bs)
			p++;
		lft = (p > 0) && (seg_start[p - 1] + seg_size[p - 1] == bs);
		rgt = (p < seg_cnt) && (bs + bz == seg_start[p]);
		if (lft && rgt) begin
			seg_size[p - 1] += bz + seg_size[p];
			drop_seg(p);
		end else if (lft) begin
			seg_size[p - 1] += bz;
		end else if (rgt) begin
			seg_start[p] = bs;
			seg_size[p] += bz;
		end else begin
			if (seg_cnt >= ENTRIES) begin
				o.status = vpa_pkg::ST_NO_SPACE;
				return o;
			end
			for (int unsigned k = seg_cnt; k > p; k--) begin
				seg_start[k] = seg_start[k - 1];
				seg_size[k] = seg_size[k - 1];
			end
			seg_start[p] = bs;
			seg_size[p] = bz;
			seg_cnt++;
		end
		for (int unsigned k = idx; k + 1 < blk_cnt; k++) begin
			blk_pid[k] = blk_pid[k + 1];
			blk_start[k] = blk_start[k + 1];
			blk_size[k] = blk_size[k + 1];
		end
		blk_cnt--;
		o.status = vpa_pkg::ST_DONE;
		o.grant_addr = bs[15:0];
		o.granted_size = bz[15:0];
		return o;
	endfunction

	function automatic vpa_pkg::rsp_t predict_result(vpa_pkg::req_t r);
		if (r.cmd == vpa_pkg::CMD_ALLOC)
			return predict_alloc(r.req_size);
		return predict_free(r.target_pid);
	endfunction

	// drive one request; typed expectation used when given
	task automatic send_request(vpa_pkg::req_t r, bit typed, vpa_pkg::rsp_t want);
		vpa_pkg::rsp_t got;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		got = predict_result(r);
		pending_rsp.push_back(typed ? want : got);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		drain();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			vpa_pkg::REG_FIT: m_fit = val[1:0];
			vpa_pkg::REG_MEM: begin
				m_mem = val;
				clear_tables();
			end
			vpa_pkg::REG_FRAG: m_frag = val;
			default: ;
		endcase
	endtask

	function automatic vpa_pkg::req_t random_request();
		vpa_pkg::req_t r;
		int unsigned span;
		r.cmd = ($urandom_range(0, 99) < 60) ? vpa_pkg::CMD_ALLOC : vpa_pkg::CMD_FREE;
		r.req_size = 16'($urandom());
		r.target_pid = 16'($urandom());
		span = (m_mem / 6) + 1;
		if (r.cmd == vpa_pkg::CMD_ALLOC) begin
			case ($urandom_range(0, 9))
				0: r.req_size = 16'd0;
				1: ;
				2: r.req_size = 16'($urandom_range(1, (m_mem > 0) ? m_mem : 1));
				default: r.req_size = 16'($urandom_range(1, span));
			endcase
		end else if (blk_cnt != 0 && $urandom_range(0, 9) < 8) begin
			r.target_pid = 16'(blk_pid[$urandom_range(0, blk_cnt - 1)]);
		end
		return r;
	endfunction

	typedef struct {
		vpa_pkg::req_t r;
		bit            typed;
		vpa_pkg::rsp_t want;
	} stim_row_t;

	stim_row_t stim_rows [] = '{
		'{'{vpa_pkg::CMD_ALLOC, 16'd0, 16'hFFFF}, 1'b1,
			'{vpa_pkg::ST_ZERO, 16'd1, 16'd0, 16'd0}},
		'{'{vpa_pkg::CMD_ALLOC, 16'd100, 16'd0}, 1'b1,
			'{vpa_pkg::ST_DONE, 16'd2, 16'd0, 16'd100}},
		'{'{vpa_pkg::CMD_ALLOC, 16'd200, 16'd0}, 1'b1,
			'{vpa_pkg::ST_DONE, 16'd3, 16'd100, 16'd200}},
		'{'{vpa_pkg::CMD_ALLOC, 16'hFFFF, 16'hFFFF}, 1'b1,
			'{vpa_pkg::ST_NO_SPACE, 16'd4, 16'd0, 16'd0}},
		'{'{vpa_pkg::CMD_FREE, 16'hFFFF, 16'd999}, 1'b1,
			'{vpa_pkg::ST_NOT_FND, 16'd999, 16'd0, 16'd0}},
		'{'{vpa_pkg::CMD_FREE, 16'd0, 16'd2}, 1'b1,
			'{vpa_pkg::ST_DONE, 16'd2, 16'd0, 16'd100}},
		'{'{vpa_pkg::CMD_ALLOC, 16'd95, 16'd0}, 1'b1,
			'{vpa_pkg::ST_DONE, 16'd5, 16'd0, 16'd100}},
		'{'{vpa_pkg::CMD_FREE, 16'd0, 16'hFFFF}, 1'b1,
			'{vpa_pkg::ST_NOT_FND, 16'hFFFF, 16'd0, 16'd0}},
		'{'{vpa_pkg::CMD_ALLOC, 16'd724, 16'd0},  1'b0, '0},
		'{'{vpa_pkg::CMD_FREE, 16'd0, 16'd3},     1'b0, '0},
		'{'{vpa_pkg::CMD_FREE, 16'd0, 16'd5},     1'b0, '0},
		'{'{vpa_pkg::CMD_ALLOC, 16'd50, 16'd0},   1'b0, '0},
		'{'{vpa_pkg::CMD_ALLOC, 16'd60, 16'd0},   1'b0, '0},
		'{'{vpa_pkg::CMD_ALLOC, 16'd70, 16'd0},   1'b0, '0},
		'{'{vpa_pkg::CMD_FREE, 16'd0, 16'd10},    1'b0, '0},
		'{'{vpa_pkg::CMD_ALLOC, 16'd100, 16'd0},  1'b0, '0},
		'{'{vpa_pkg::CMD_FREE, 16'd0, 16'd6},     1'b0, '0},
		'{'{vpa_pkg::CMD_FREE, 16'd0, 16'd12},    1'b0, '0},
		'{'{vpa_pkg::CMD_ALLOC, 16'd700, 16'd0},  1'b0, '0},
		'{'{vpa_pkg::CMD_ALLOC, 16'd200, 16'd0},  1'b0, '0}
	};

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				report("unexpected response pid", rsp.granted_pid, 0);
			end else begin
				if (rsp.status != pending_rsp[0].status)
					report("status", rsp.status, pending_rsp[0].status);
				if (rsp.granted_pid != pending_rsp[0].granted_pid)
					report("granted_pid", rsp.granted_pid, pending_rsp[0].granted_pid);
				if (rsp.grant_addr != pending_rsp[0].grant_addr)
					report("grant_addr", rsp.grant_addr, pending_rsp[0].grant_addr);
				if (rsp.granted_size != pending_rsp[0].granted_size)
					report("granted_size", rsp.granted_size, pending_rsp[0].granted_size);
				void'(pending_rsp.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_MAX) begin
			$display("tb_variable_partition_allocator: errors");
			$finish;
		end
	end

	initial begin
		forever begin
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (!quiet) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	typedef struct {
		logic [1:0]  fit;
		logic [15:0] mem;
		logic [15:0] frag;
	} setting_t;

	setting_t settings [] = '{
		'{vpa_pkg::FIT_BEST, 16'd300, 16'd0},
		'{vpa_pkg::FIT_WORST, 16'hFFFF, 16'hFFFF},
		'{vpa_pkg::FIT_RSVD, 16'd1, 16'd0},
		'{vpa_pkg::FIT_WORST, 16'd0, 16'd5},
		'{vpa_pkg::FIT_FIRST, 16'd2000, 16'd4},
		'{vpa_pkg::FIT_BEST, 16'd800, 16'd10}
	};

	initial begin
		m_fit = vpa_pkg::FIT_FIRST;
		m_mem = vpa_pkg::RESET_MEMORY;
		m_frag = vpa_pkg::RESET_MIN_FRAG;
		pid_next = 0;
		clear_tables();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stim_rows[i])
			send_request(stim_rows[i].r, stim_rows[i].typed, stim_rows[i].want);
		for (int n = 0; n < 60; n++)
			send_request(random_request(), 1'b0, '0);
		foreach (settings[s]) begin
			write_reg(vpa_pkg::REG_FIT, settings[s].fit);
			write_reg(vpa_pkg::REG_FRAG, settings[s].frag);
			write_reg(vpa_pkg::REG_MEM, settings[s].mem);
			if (s == settings.size() - 1)
				quiet = 1'b1;
			for (int n = 0; n < 100; n++) begin
				if (s == 0 && n == 50)
					drain();
				send_request(random_request(), 1'b0, '0);
			end
		end
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("tb_variable_partition_allocator: clean");
		else
			$display("tb_variable_partition_allocator: errors");
		$finish;
	end

endmodule
